>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int KEY_W    = 32;
  localparam int TAG_W    = 32;
  localparam int STATUS_W = 2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Per-cycle operation broadcast to every cell.
  typedef struct packed {
    logic push;  // accepted push into a queue that has room
    logic pop;   // accepted pop from a queue that holds an entry
  } cell_ctrl_t;

endpackage

>>> hdl/spq_cell.sv
// One slot of the shift-register queue: holds, inserts or shifts an entry.
module spq_cell import spq_pkg::*; #(
  parameter int PW = 32
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic              occ_i,
  input  logic              left_keep_i,
  input  logic [KEY_W-1:0]  left_key_i,
  input  logic [PW-1:0]     left_pay_i,
  input  logic [KEY_W-1:0]  right_key_i,
  input  logic [PW-1:0]     right_pay_i,
  input  logic [KEY_W-1:0]  new_key_i,
  input  logic [PW-1:0]     new_pay_i,
  output logic              keep_o,
  output logic [KEY_W-1:0]  key_o,
  output logic [PW-1:0]     pay_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [PW-1:0]    pay_q, pay_d;

  // Held entry stays put when its key is no larger than the new one.
  assign keep_o = occ_i && ($signed(key_q) <= $signed(new_key_i));

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.push && !keep_o) begin
      if (left_keep_i) begin
        key_d = new_key_i;
        pay_d = new_pay_i;
      end else begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
      pay_d = right_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of cells kept in key order.
// Each result is registered and appears in the cycle after its start transfer, for one cycle.
// Throughput: one push or pop per cycle; every cell compares against the new
// key in parallel and shifts with its neighbor in the same cycle.
// busy_o stays low; the receiver cannot stall the result strobe.
// Reset empties the queue (count to zero); slot contents are not cleared.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY     = 16,
  parameter int PAYLOAD_BITS = 32,
  localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    command_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic [TAG_W-1:0]        payload_i,
  output logic                    result_valid_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic signed [KEY_W-1:0] out_key_o,
  output logic [TAG_W-1:0]        out_payload_o,
  output logic [CNT_W-1:0]        occupancy_o
);

  localparam int PW = (PAYLOAD_BITS < TAG_W) ? PAYLOAD_BITS : TAG_W;

  logic                    accept;
  logic                    is_full, is_empty;
  cell_ctrl_t              ctrl;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    valid_q;
  status_e                 status_q, status_d;
  logic [KEY_W-1:0]        okey_q, okey_d;
  logic [TAG_W-1:0]        opay_q, opay_d;
  logic [PW-1:0]           new_pay;

  logic [CAPACITY-1:0]     occ;
  logic [CAPACITY:0]       keep;
  logic [KEY_W-1:0]        cell_key [CAPACITY+1];
  logic [PW-1:0]           cell_pay [CAPACITY+1];

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign new_pay  = payload_i[PW-1:0];

  assign ctrl.push = accept && (command_i == CMD_PUSH) && !is_full;
  assign ctrl.pop  = accept && (command_i == CMD_POP) && !is_empty;

  // Virtual cell ahead of the head always keeps; past the tail feeds zeros.
  assign keep[0]            = 1'b1;
  assign cell_key[CAPACITY] = '0;
  assign cell_pay[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic [PW-1:0]    left_pay;

    assign occ[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_key = key_i;
      assign left_pay = new_pay;
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_pay = cell_pay[i-1];
    end

    spq_cell #(.PW(PW)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .left_keep_i (keep[i]),
      .left_key_i  (left_key),
      .left_pay_i  (left_pay),
      .right_key_i (cell_key[i+1]),
      .right_pay_i (cell_pay[i+1]),
      .new_key_i   (key_i),
      .new_pay_i   (new_pay),
      .keep_o      (keep[i+1]),
      .key_o       (cell_key[i]),
      .pay_o       (cell_pay[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_PUSHED;
    okey_d   = '0;
    opay_d   = '0;
    if (command_i == CMD_PUSH) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_POPPED;
        okey_d   = cell_key[0];
        opay_d   = TAG_W'(cell_pay[0]);
        count_d  = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      opay_q   <= opay_d;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign out_key_o      = okey_q;
  assign out_payload_o  = opay_q;
  assign occupancy_o    = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result without an accepted item");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> (count_q + CNT_W'(1) == $past(count_q)))
    else $error("pop did not drop one entry");

endmodule

>>> test/sorted_priority_queue_test.sv
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
module sorted_priority_queue_test import spq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE_LEN   = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PLAN_ROWS    = 11;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [TAG_W-1:0]    tag;
    logic [CNT_W-1:0]    occ;
  } outcome_t;

  typedef struct packed {
    command_e         cmd;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    int               reps;
    logic             typed;
    outcome_t         want;
  } plan_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    command_i;
  logic signed [KEY_W-1:0] key_i;
  logic [TAG_W-1:0]        payload_i;
  logic                    result_valid_o;
  logic [STATUS_W-1:0]     status_o;
  logic signed [KEY_W-1:0] out_key_o;
  logic [TAG_W-1:0]        out_payload_o;
  logic [CNT_W-1:0]        occupancy_o;

  // Shadow of the queue contents, smallest key first.
  logic [KEY_W-1:0] held_key [DEPTH];
  logic [TAG_W-1:0] held_tag [DEPTH];
  int               held_count = 0;

  outcome_t pending_q [$];
  outcome_t oldest;
  int       errors = 0;
  int       cycle_count = 0;

  // Results are typed in only where they are obvious; the rest come from the shadow queue.
  plan_row_t plan [PLAN_ROWS] = '{
    '{CMD_POP,  32'h0000_0000, 32'h0000_0000, 1,  1'b1, '{ST_EMPTY,  32'h0, 32'h0, 5'd0}},
    '{CMD_PUSH, 32'h7fff_ffff, 32'hffff_ffff, 1,  1'b1, '{ST_PUSHED, 32'h0, 32'h0, 5'd1}},
    '{CMD_PUSH, 32'h8000_0000, 32'h0000_0000, 1,  1'b1, '{ST_PUSHED, 32'h0, 32'h0, 5'd2}},
    '{CMD_PUSH, 32'h0000_0000, 32'ha5a5_a5a5, 1,  1'b0, '0},
    '{CMD_PUSH, 32'hffff_ffff, 32'h5a5a_5a5a, 1,  1'b0, '0},
    '{CMD_POP,  32'hdead_beef, 32'h1234_5678, 1,  1'b1,
      '{ST_POPPED, 32'h8000_0000, 32'h0, 5'd3}},
    '{CMD_PUSH, 32'h0000_0000, 32'h0000_0100, 13, 1'b0, '0},
    '{CMD_PUSH, 32'h0000_0001, 32'h1234_5678, 1,  1'b1, '{ST_FULL,   32'h0, 32'h0, 5'd16}},
    '{CMD_POP,  32'h0000_0000, 32'h0000_0000, 1,  1'b0, '0},
    '{CMD_POP,  32'hffff_ffff, 32'hffff_ffff, 2,  1'b0, '0},
    '{CMD_PUSH, 32'h8000_0000, 32'hffff_ffff, 1,  1'b0, '0}
  };

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .key_i          (key_i),
    .payload_i      (payload_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_key_o      (out_key_o),
    .out_payload_o  (out_payload_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one item to the shadow queue and return the result it should produce.
  function automatic outcome_t queue_update(command_e cmd, logic [KEY_W-1:0] key,
                                            logic [TAG_W-1:0] tag);
    outcome_t res;
    int       slot;
    res = '{ST_PUSHED, '0, '0, '0};
    if (cmd == CMD_PUSH) begin
      if (held_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Insert after every equal key so ties leave in arrival order.
        slot = 0;
        while (slot < held_count && $signed(held_key[slot]) <= $signed(key)) slot++;
        for (int i = held_count; i > slot; i--) begin
          held_key[i] = held_key[i-1];
          held_tag[i] = held_tag[i-1];
        end
        held_key[slot] = key;
        held_tag[slot] = tag;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = ST_POPPED;
      res.key    = held_key[0];
      res.tag    = held_tag[0];
      for (int i = 1; i < held_count; i++) begin
        held_key[i-1] = held_key[i];
        held_tag[i-1] = held_tag[i];
      end
      held_count--;
    end
    res.occ = held_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    // Crowd keys near zero to get plenty of ties.
    if (r < 35) return KEY_W'($urandom_range(0, 16)) - KEY_W'(8);
    if (r < 45) begin
      case ($urandom_range(0, 5))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h8000_0001;
        3:       return 32'h7fff_fffe;
        4:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the item on the ports until the block takes it.
  task automatic transfer(input command_e cmd, input logic [KEY_W-1:0] key,
                          input logic [TAG_W-1:0] tag, input logic typed, input outcome_t want);
    outcome_t predicted;
    start_i   <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    payload_i <= tag;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = queue_update(cmd, key, tag);
    pending_q.push_back(typed ? want : predicted);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop start only while results are still owed, so a following transfer
  // never drives start in the same step.
  task automatic drain();
    if (pending_q.size() != 0) begin
      start_i <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string field, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o !== 1'b0) begin
      if (pending_q.size() == 0) begin
        $display("%0t ns: result with nothing pending, expected none, actual %h %h %h %h",
                 $time, status_o, out_key_o, out_payload_o, occupancy_o);
        errors++;
      end else begin
        oldest = pending_q.pop_front();
        check_field("status", KEY_W'(oldest.status), KEY_W'(status_o));
        check_field("out_key", oldest.key, out_key_o);
        check_field("out_payload", oldest.tag, out_payload_o);
        check_field("occupancy", KEY_W'(oldest.occ), KEY_W'(occupancy_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int       sent;
    int       phase_len;
    int       push_pct;
    logic     steady;
    command_e cmd;
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    command_i <= CMD_PUSH;
    key_i     <= '0;
    payload_i <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        transfer(plan[r].cmd, plan[r].key, plan[r].tag + TAG_W'(k), plan[r].typed,
                 plan[r].want);
        idle(pick_gap());
      end
    end
    drain();

    // Phases lean toward pushes or pops so the queue swings between full and empty.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0:       push_pct = 90;
        1:       push_pct = 70;
        2:       push_pct = 50;
        3:       push_pct = 35;
        default: push_pct = 15;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        transfer(cmd, pick_key(), $urandom(), 1'b0, '0);
        sent++;
        idle(steady ? 0 : pick_gap());
      end
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    start_i <= 1'b0;
    repeat (SETTLE_LEN) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
